>>> rtl/pfa_pkg.sv
`timescale 1ns / 1ps
// Package for the partition fit allocator: sizes, codes and the structs
// shared by the slot cell chain and the top level. No dependencies.
package pfa_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int SIZE_BITS = 16;

    // Width that can hold a slot count up to MAX_SLOTS
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    // Slot id width: covers the 5-bit load index, the 6-bit count and CNT_W
    localparam int ID_W  = (CNT_W > 6) ? CNT_W : 6;
    // Compare width for sizes against 16-bit requests
    localparam int CMP_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;

    // Item kinds
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // Placement policies; the unused code behaves as first fit
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Result status
    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // Configuration register indexes
    localparam logic CFG_FIT_MODE   = 1'b0;
    localparam logic CFG_PART_COUNT = 1'b1;

    typedef struct packed {
        logic        func;
        logic [4:0]  slot_index;
        logic [15:0] amount_kb;
        logic [7:0]  requester_id;
    } alloc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  chosen_slot;
        logic [7:0]  owner_id;
        logic [15:0] leftover_kb;
    } alloc_out_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                 active;
        logic                 found;
        logic [ID_W-1:0]      best_idx;
        logic [SIZE_BITS-1:0] best_size;
    } srch_tok_t;

    // Search parameters, held steady for the whole pass
    typedef struct packed {
        logic [15:0]     need;
        logic [1:0]      mode;
        logic [ID_W-1:0] limit;
    } srch_ctl_t;

    // Slot update broadcast: load a size or mark a slot taken
    typedef struct packed {
        logic                 load_en;
        logic                 grant_en;
        logic [ID_W-1:0]      idx;
        logic [SIZE_BITS-1:0] size;
    } slot_cmd_t;

endpackage

>>> rtl/partition_fit_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the fixed-partition allocator: handshakes, config registers,
// control sequencer and the chain of pfa_cell slots. Depends on pfa_pkg.
//
// Load items (func 0) write their slot at acceptance and give no result. An
// allocate item sends a search token down the chain of MAX_SLOTS slot cells,
// one cell per cycle; the outcome at the chain's end is registered as the
// pending result, ST_FIN writes it into the result register, and then the
// next item can be taken. A request refused after an earlier failure skips
// the search and goes from ST_FIN straight into the result register.
// One item is worked on at a time; a result may wait in the output register
// while the next item is taken in, but a finished request holds the input
// stalled until the output register is free. fit_mode and partition_count
// may only be written while the block is idle.
module partition_fit_allocator_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pfa_pkg::alloc_in_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output pfa_pkg::alloc_out_t out_item,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [5:0]          cfg_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FIN    = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 mode_reg;
    logic [5:0]                 count_reg;
    logic                       halted_reg, halted_next;
    logic                       out_valid_reg, out_valid_next;
    pfa_pkg::alloc_out_t        out_item_reg, out_item_next;
    logic [15:0]                need_reg, need_next;
    logic [7:0]                 id_reg, id_next;
    logic [1:0]                 pend_status_reg, pend_status_next;
    logic [pfa_pkg::ID_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [15:0]                pend_left_reg, pend_left_next;

    logic                       accept;
    logic                       search_start;
    logic [pfa_pkg::ID_W-1:0]   count_ext;
    logic [pfa_pkg::CMP_W-1:0]  left_full;
    pfa_pkg::srch_ctl_t         ctl;
    pfa_pkg::slot_cmd_t         cmd;
    pfa_pkg::srch_tok_t         tok [pfa_pkg::MAX_SLOTS+1];

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // count above the slot total is clamped
    assign count_ext = pfa_pkg::ID_W'(count_reg);
    assign ctl.limit = (count_ext > pfa_pkg::ID_W'(pfa_pkg::MAX_SLOTS)) ?
                       pfa_pkg::ID_W'(pfa_pkg::MAX_SLOTS) : count_ext;
    // the first cell compares in the accepting cycle, before need_reg is loaded
    assign ctl.need  = (state_reg == ST_IDLE) ? in_item.amount_kb : need_reg;
    assign ctl.mode  = mode_reg;

    assign tok[0] = '{active: search_start, found: 1'b0, best_idx: '0, best_size: '0};

    assign left_full = pfa_pkg::CMP_W'(tok[pfa_pkg::MAX_SLOTS].best_size) -
                       pfa_pkg::CMP_W'(need_reg);

    always_comb
    begin
        state_next       = state_reg;
        halted_next      = halted_reg;
        out_valid_next   = out_valid_reg;
        out_item_next    = out_item_reg;
        need_next        = need_reg;
        id_next          = id_reg;
        pend_status_next = pend_status_reg;
        pend_idx_next    = pend_idx_reg;
        pend_left_next   = pend_left_reg;

        search_start = 1'b0;

        cmd.load_en  = 1'b0;
        cmd.grant_en = 1'b0;
        cmd.idx      = pfa_pkg::ID_W'(in_item.slot_index);
        cmd.size     = pfa_pkg::SIZE_BITS'(in_item.amount_kb);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    need_next = in_item.amount_kb;
                    id_next   = in_item.requester_id;
                    if (in_item.func == pfa_pkg::FUNC_LOAD)
                    begin
                        cmd.load_en = 1'b1;
                        halted_next = 1'b0;
                    end
                    else if (halted_reg)
                    begin
                        pend_status_next = pfa_pkg::ST_REFUSED;
                        pend_idx_next    = '0;
                        pend_left_next   = '0;
                        state_next       = ST_FIN;
                    end
                    else
                    begin
                        search_start = 1'b1;
                        state_next   = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tok[pfa_pkg::MAX_SLOTS].active)
                begin
                    if (tok[pfa_pkg::MAX_SLOTS].found)
                    begin
                        pend_status_next = pfa_pkg::ST_GRANTED;
                        pend_idx_next    = tok[pfa_pkg::MAX_SLOTS].best_idx;
                        pend_left_next   = left_full[15:0];
                    end
                    else
                    begin
                        pend_status_next = pfa_pkg::ST_NO_FIT;
                        pend_idx_next    = '0;
                        pend_left_next   = '0;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.status      = pend_status_reg;
                    out_item_next.chosen_slot = 5'(pend_idx_reg);
                    out_item_next.owner_id    = id_reg;
                    out_item_next.leftover_kb = pend_left_reg;
                    if (pend_status_reg == pfa_pkg::ST_NO_FIT)
                    begin
                        halted_next = 1'b1;
                    end
                    if (pend_status_reg == pfa_pkg::ST_GRANTED)
                    begin
                        cmd.grant_en = 1'b1;
                        cmd.idx      = pend_idx_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < pfa_pkg::MAX_SLOTS; g++)
        begin : g_cell
            pfa_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .cell_id (pfa_pkg::ID_W'(g)),
                .ctl     (ctl),
                .cmd     (cmd),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= pfa_pkg::FIT_FIRST;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pfa_pkg::CFG_FIT_MODE:   mode_reg  <= cfg_data[1:0];
                    pfa_pkg::CFG_PART_COUNT: count_reg <= cfg_data;
                    default:                 count_reg <= count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg    <= out_item_next;
        need_reg        <= need_next;
        id_reg          <= id_next;
        pend_status_reg <= pend_status_next;
        pend_idx_reg    <= pend_idx_next;
        pend_left_reg   <= pend_left_next;
    end

endmodule

>>> rtl/pfa_cell.sv
`timescale 1ns / 1ps
// One partition slot of the allocator chain: holds size and busy flag,
// compares against the passing search token and registers it onward.
// Depends on pfa_pkg.
module pfa_cell
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [pfa_pkg::ID_W-1:0] cell_id,
    input  pfa_pkg::srch_ctl_t       ctl,
    input  pfa_pkg::slot_cmd_t       cmd,
    input  pfa_pkg::srch_tok_t       tok_in,
    output pfa_pkg::srch_tok_t       tok_out
);

    logic [pfa_pkg::SIZE_BITS-1:0] size_reg;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          active_reg;
    logic                          found_reg;
    logic [pfa_pkg::ID_W-1:0]      best_idx_reg;
    logic [pfa_pkg::SIZE_BITS-1:0] best_size_reg;
    pfa_pkg::srch_tok_t            tok_next;
    logic                          eligible;
    logic                          better;

    always_comb
    begin
        eligible = tok_in.active && (cell_id < ctl.limit) && !busy_reg &&
                   (pfa_pkg::CMP_W'(size_reg) >= pfa_pkg::CMP_W'(ctl.need));
        // ties keep the earlier (lower) slot
        better = !tok_in.found ||
                 ((ctl.mode == pfa_pkg::FIT_BEST)  && (size_reg < tok_in.best_size)) ||
                 ((ctl.mode == pfa_pkg::FIT_WORST) && (size_reg > tok_in.best_size));
        tok_next = tok_in;
        if (eligible && better)
        begin
            tok_next.found     = 1'b1;
            tok_next.best_idx  = cell_id;
            tok_next.best_size = size_reg;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.load_en && (cmd.idx == cell_id))
        begin
            busy_next = 1'b0;
        end
        else if (cmd.grant_en && (cmd.idx == cell_id))
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            active_reg <= tok_next.active;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg     <= tok_next.found;
        best_idx_reg  <= tok_next.best_idx;
        best_size_reg <= tok_next.best_size;
        if (cmd.load_en && (cmd.idx == cell_id))
        begin
            size_reg <= cmd.size;
        end
    end

    assign tok_out = '{active: active_reg, found: found_reg,
                       best_idx: best_idx_reg, best_size: best_size_reg};

endmodule

>>> sim/tb_partition_fit_allocator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for partition_fit_allocator_unit: a queue-fed driver,
// a monitor and an in-line model of the partition search. Depends on pfa_pkg.
module tb_partition_fit_allocator_unit;

    localparam int          SETTLE_CYCLES = 40;  // covers the search walk
    localparam int          RAND_ITEMS    = 1650;
    localparam int          PHASES        = 12;
    localparam logic [1:0]  FIT_SPARE     = 2'd3;

    typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN, STEP_PACE} step_kind_t;

    typedef struct packed {
        step_kind_t          kind;
        pfa_pkg::alloc_in_t  item;
        logic                cfg_idx;
        logic [5:0]          cfg_val;
        logic [6:0]          send_pct;
        logic [6:0]          recv_pct;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    pfa_pkg::alloc_in_t  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    pfa_pkg::alloc_out_t out_item;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [5:0]          cfg_data = 6'd0;

    // Model state of the allocator
    logic [pfa_pkg::SIZE_BITS-1:0] part_size [pfa_pkg::MAX_SLOTS];
    bit                            part_busy [pfa_pkg::MAX_SLOTS];
    bit                            alloc_halted = 1'b0;
    logic [1:0]                    fit_sel = pfa_pkg::FIT_FIRST;
    logic [5:0]                    part_limit = 6'd0;

    step_t               step_q[$];
    pfa_pkg::alloc_out_t grant_q[$];
    bit                  item_taken = 1'b0;
    bit                  stim_done = 1'b0;
    int                  settle_left = 0;
    int                  send_pct = 0;
    int                  recv_pct = 0;
    int                  error_count = 0;

    partition_fit_allocator_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Returns 1 when the item gives a result, placed in res
    function automatic bit predict_allocation(input pfa_pkg::alloc_in_t it,
                                              output pfa_pkg::alloc_out_t res);
        int lim;
        int pick;
        res = '0;
        res.owner_id = it.requester_id;
        if (it.func == pfa_pkg::FUNC_LOAD)
        begin
            part_size[it.slot_index] = it.amount_kb;
            part_busy[it.slot_index] = 1'b0;
            alloc_halted = 1'b0;
            return 1'b0;
        end
        if (alloc_halted)
        begin
            res.status = pfa_pkg::ST_REFUSED;
            return 1'b1;
        end
        lim  = (part_limit > pfa_pkg::MAX_SLOTS) ? pfa_pkg::MAX_SLOTS : int'(part_limit);
        pick = -1;
        for (int k = 0; k < lim; k++)
        begin
            if (part_busy[k] || part_size[k] < it.amount_kb)
                continue;
            if (pick < 0)
                pick = k;
            else if (fit_sel == pfa_pkg::FIT_BEST && part_size[k] < part_size[pick])
                pick = k;
            else if (fit_sel == pfa_pkg::FIT_WORST && part_size[k] > part_size[pick])
                pick = k;
        end
        if (pick < 0)
        begin
            alloc_halted = 1'b1;
            res.status = pfa_pkg::ST_NO_FIT;
            return 1'b1;
        end
        part_busy[pick]  = 1'b1;
        res.status      = pfa_pkg::ST_GRANTED;
        res.chosen_slot = 5'(pick);
        res.leftover_kb = 16'(part_size[pick] - it.amount_kb);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endtask

    task automatic push_step(input step_kind_t kind, input pfa_pkg::alloc_in_t it,
                             input logic idx, input logic [5:0] val,
                             input logic [6:0] sp, input logic [6:0] rp);
        step_t st;
        st.kind     = kind;
        st.item     = it;
        st.cfg_idx  = idx;
        st.cfg_val  = val;
        st.send_pct = sp;
        st.recv_pct = rp;
        step_q.push_back(st);
    endtask

    task automatic push_item(input logic f, input logic [4:0] s, input logic [15:0] a,
                             input logic [7:0] id);
        push_step(STEP_ITEM, pfa_pkg::alloc_in_t'({f, s, a, id}), 1'b0, 6'd0, 7'd0, 7'd0);
    endtask

    task automatic push_pace(input logic [6:0] sp, input logic [6:0] rp);
        push_step(STEP_PACE, '0, 1'b0, 6'd0, sp, rp);
    endtask

    // Registers only change once the block has drained
    task automatic push_setting(input logic [1:0] mode, input logic [5:0] count);
        push_step(STEP_DRAIN, '0, 1'b0, 6'd0, 7'd0, 7'd0);
        push_step(STEP_CFG, '0, pfa_pkg::CFG_FIT_MODE, {4'd0, mode}, 7'd0, 7'd0);
        push_step(STEP_CFG, '0, pfa_pkg::CFG_PART_COUNT, count, 7'd0, 7'd0);
    endtask

    // Monitor: config shadow, prediction on acceptance, result checks
    always @(posedge clk)
    begin : monitor
        pfa_pkg::alloc_out_t want;
        if (rst_n)
        begin
            item_taken <= in_valid && !in_stall;
            if (cfg_we)
            begin
                if (cfg_index == pfa_pkg::CFG_FIT_MODE)
                    fit_sel = cfg_data[1:0];
                else
                    part_limit = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (predict_allocation(in_item, want))
                    grant_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (grant_q.size() == 0)
                begin
                    $error("result with none expected: %p", out_item);
                    error_count++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    check_field("status", 16'(want.status), 16'(out_item.status));
                    check_field("chosen_slot", 16'(want.chosen_slot),
                                16'(out_item.chosen_slot));
                    check_field("owner_id", 16'(want.owner_id), 16'(out_item.owner_id));
                    check_field("leftover_kb", want.leftover_kb, out_item.leftover_kb);
                end
            end
        end
    end

    // Driver: works through the step queue on the falling edge
    always @(negedge clk)
    begin : driver
        step_t st;
        logic  nxt_valid;
        logic  nxt_we;
        if (rst_n)
        begin
            nxt_valid = in_valid && !item_taken;
            nxt_we    = 1'b0;
            if (!nxt_valid)
            begin
                if (settle_left > 0)
                    settle_left--;
                else if (step_q.size() != 0)
                begin
                    st = step_q[0];
                    case (st.kind)
                        STEP_ITEM:
                        begin
                            if ($urandom_range(99) >= send_pct)
                            begin
                                nxt_valid = 1'b1;
                                in_item <= st.item;
                                step_q.delete(0);
                            end
                        end
                        STEP_CFG:
                        begin
                            nxt_we = 1'b1;
                            cfg_index <= st.cfg_idx;
                            cfg_data  <= st.cfg_val;
                            step_q.delete(0);
                        end
                        STEP_DRAIN:
                        begin
                            if (grant_q.size() == 0)
                            begin
                                settle_left = SETTLE_CYCLES;
                                step_q.delete(0);
                            end
                        end
                        default:
                        begin
                            send_pct = st.send_pct;
                            recv_pct = st.recv_pct;
                            step_q.delete(0);
                        end
                    endcase
                end
                else
                    stim_done <= 1'b1;
            end
            in_valid  <= nxt_valid;
            cfg_we    <= nxt_we;
            out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    initial
    begin : stimulus
        logic [1:0]          mode;
        logic [5:0]          count;
        logic [15:0]         amt;
        pfa_pkg::alloc_in_t  it;
        int                  load_pct;

        push_pace(7'd7, 7'd53);
        // Reset config has no partitions in use: a failure, then a refusal
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'd100, 8'h00);
        push_item(pfa_pkg::FUNC_ALLOC, 5'd31, 16'hFFFF, 8'hFF);
        // Load every partition so no search meets an unloaded size
        for (int k = 0; k < pfa_pkg::MAX_SLOTS; k++)
            push_item(pfa_pkg::FUNC_LOAD, 5'(k), 16'(k * 100), 8'(k));
        push_setting(pfa_pkg::FIT_FIRST, 6'd63);
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 8'h01);    // zero request takes the empty slot
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'd150, 8'h02);
        push_setting(pfa_pkg::FIT_BEST, 6'd32);
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'd250, 8'h03);
        push_item(pfa_pkg::FUNC_LOAD, 5'd30, 16'hFFFF, 8'h00);
        push_item(pfa_pkg::FUNC_LOAD, 5'd31, 16'hFFFF, 8'h00);
        push_setting(pfa_pkg::FIT_WORST, 6'd32);
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'd1, 8'h04);    // tie between the two largest
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'hFFFF, 8'h05);
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'hFFFF, 8'h06);
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'd1, 8'h07);
        push_item(pfa_pkg::FUNC_LOAD, 5'd30, 16'hFFFF, 8'h00); // reload of a taken slot
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'hFFFF, 8'hFF);
        push_setting(FIT_SPARE, 6'd32);
        push_item(pfa_pkg::FUNC_ALLOC, 5'd0, 16'd10, 8'h09);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 4)
                push_pace(7'd53, 7'd7);
            else if (ph == 8)
                push_pace(7'd0, 7'd0);
            case (ph)
                0: begin mode = pfa_pkg::FIT_FIRST; count = 6'd32; end
                1: begin mode = pfa_pkg::FIT_BEST;  count = 6'd32; end
                2: begin mode = pfa_pkg::FIT_WORST; count = 6'd32; end
                3: begin mode = FIT_SPARE;          count = 6'd63; end
                4: begin mode = pfa_pkg::FIT_BEST;  count = 6'($urandom_range(31, 1)); end
                5: begin mode = pfa_pkg::FIT_WORST; count = 6'd0; end
                6: begin mode = pfa_pkg::FIT_FIRST; count = 6'd1; end
                7: begin mode = pfa_pkg::FIT_WORST; count = 6'($urandom_range(63, 33)); end
                default:
                begin
                    mode  = 2'($urandom_range(3));
                    count = 6'($urandom_range(63));
                end
            endcase
            push_setting(mode, count);
            load_pct = $urandom_range(55, 25);
            for (int n = 0; n < RAND_ITEMS / PHASES; n++)
            begin
                // Coarse sizes make ties common for best and worst fit
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: amt = 16'($urandom_range(16) * 64);
                    5, 6, 7:       amt = 16'($urandom_range(4095));
                    8:             amt = 16'($urandom);
                    default:       amt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                endcase
                it.func = ($urandom_range(99) < load_pct) ? pfa_pkg::FUNC_LOAD
                                                          : pfa_pkg::FUNC_ALLOC;
                if (it.func == pfa_pkg::FUNC_ALLOC && $urandom_range(1))
                    amt = amt >> 1;
                it.slot_index   = 5'($urandom_range(31));
                it.amount_kb    = amt;
                it.requester_id = 8'($urandom_range(255));
                push_step(STEP_ITEM, it, 1'b0, 6'd0, 7'd0, 7'd0);
            end
        end
        push_step(STEP_DRAIN, '0, 1'b0, 6'd0, 7'd0, 7'd0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (stim_done);
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && grant_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pfa_pkg.sv
rtl/pfa_cell.sv
rtl/partition_fit_allocator_unit.sv
sim/tb_partition_fit_allocator_unit.sv
